// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define GMV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define GMV_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/gmv_pkg.sv =====
// Shared constants and types for the Gaussian MAP mean and variance update block.
package gmv_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [1:0] {
        REG_MEAN_MODE  = 2'd0,
        REG_TWO_PASS   = 2'd1,
        REG_VAR_UPDATE = 2'd2,
        REG_VAR_FLOOR  = 2'd3
    } gmv_reg_e;

    typedef struct packed {
        logic mean_mode;
        logic two_pass;
        logic var_update;
    } gmv_flags_t;

endpackage

// ===== hw/rtl/gmv_regs.sv =====
// Configuration register file behind the APB-style port.
module gmv_regs
    import gmv_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int DATA_W     = 32,
    parameter int ADDR_W     = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    output gmv_flags_t            flags,
    output logic [WORD_WIDTH-1:0] var_floor
);

    localparam int SH = (DATA_W > 32) ? 3 : 2;

    gmv_flags_t            flags_reg;
    logic [WORD_WIDTH-1:0] floor_reg;
    gmv_reg_e              sel;
    logic                  wr;

    assign sel    = gmv_reg_e'(paddr[ADDR_W-1:SH]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            floor_reg <= WORD_WIDTH'(1);
        end
        else if (wr)
        begin
            unique case (sel)
                REG_MEAN_MODE:  flags_reg.mean_mode  <= pwdata[0];
                REG_TWO_PASS:   flags_reg.two_pass   <= pwdata[0];
                REG_VAR_UPDATE: flags_reg.var_update <= pwdata[0];
                REG_VAR_FLOOR:  floor_reg            <= pwdata[WORD_WIDTH-1:0];
                default:        floor_reg            <= floor_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (sel)
            REG_MEAN_MODE:  prdata[0] = flags_reg.mean_mode;
            REG_TWO_PASS:   prdata[0] = flags_reg.two_pass;
            REG_VAR_UPDATE: prdata[0] = flags_reg.var_update;
            REG_VAR_FLOOR:  prdata    = DATA_W'(floor_reg);
            default:        prdata    = '0;
        endcase
    end

    assign flags     = flags_reg;
    assign var_floor = floor_reg;

endmodule

// ===== hw/rtl/gmv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module gmv_div
#(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int SW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic          v_reg    [NW];
    logic [DW-1:0] rem_reg  [NW];
    logic [NW-1:0] num_reg  [NW];
    logic [NW-1:0] quo_reg  [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [SW-1:0] side_reg [NW];

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic          v_in;
        logic [DW-1:0] rem_in;
        logic [NW-1:0] num_in;
        logic [NW-1:0] quo_in;
        logic [DW-1:0] den_in;
        logic [SW-1:0] side_in;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW:0]   diff;
        logic [DW-1:0] rem_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign num_in  = num;
            assign quo_in  = '0;
            assign den_in  = den;
            assign side_in = side;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign num_in  = num_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb
        begin
            trial    = {rem_in, num_in[NW-1]};
            ge       = trial >= {1'b0, den_in};
            diff     = trial - {1'b0, den_in};
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                num_reg[k]  <= num_in << 1;
                quo_reg[k]  <= {quo_in[NW-2:0], ge};
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign quo       = quo_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule

// ===== hw/rtl/gaussian_map_mean_var_update.sv =====
// MAP re-estimation of one dimension of one Gaussian, Q(WORD_WIDTH-FRAC_BITS).FRAC_BITS
// fixed point. The block takes one item per cycle and returns one result word per
// item in order. The datapath runs through three chained bit-per-stage divider
// pipelines (ML mean and variance, adapted mean, adapted variance). A stalled
// result freezes the whole pipeline; with the result side ready one item enters
// every cycle. Configuration registers must only be written while no item is in
// flight.
module gaussian_map_mean_var_update
    import gmv_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DATA_W     = (WORD_WIDTH > 32) ? 64 : 32,
    parameter int ADDR_W     = (WORD_WIDTH > 32) ? 5 : 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic [WORD_WIDTH-1:0] prior_mean,
    input  logic [WORD_WIDTH-1:0] prior_var,
    input  logic [WORD_WIDTH-1:0] acc_mean,
    input  logic [WORD_WIDTH-1:0] acc_sq,
    input  logic [WORD_WIDTH-1:0] occupancy,
    input  logic [WORD_WIDTH-1:0] tau,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [WORD_WIDTH-1:0] adapted_mean,
    output logic [WORD_WIDTH-1:0] adapted_var,
    output logic                  var_valid,
    output logic                  div_fault
);

    localparam int W   = WORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int W2  = 2 * W;
    localparam int QW1 = W + F;
    localparam int MNW = (W + F > W2) ? W + F : W2;
    localparam int VNW = MNW + 2;
    localparam int DFW = ((QW1 > W2) ? QW1 : W2) + 1;

    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] UMAX = {W{1'b1}};

    typedef struct packed {
        logic [W-1:0]   pm;
        logic [W-1:0]   tau;
        logic [W-1:0]   sq;
        logic           occ_zero;
        logic [W:0]     dent;
        logic [W2-1:0]  taupv;
        logic [W-1:0]   p;
        logic           tnum_neg;
        logic [MNW-1:0] tnum_mag;
    } side1_t;

    typedef struct packed {
        logic [W-1:0]  pm;
        logic [W-1:0]  tau;
        logic [W-1:0]  sq;
        logic          occ_zero;
        logic [W:0]    dent;
        logic [W2-1:0] taupv;
        logic          mnum_neg;
        logic          mden_zero;
    } side3_t;

    typedef struct packed {
        logic [W-1:0] mean;
        logic         fault_m;
        logic         dent_zero;
    } side4_t;

    gmv_flags_t   flags;
    logic [W-1:0] var_floor;
    logic         adv;

    gmv_regs #(.WORD_WIDTH(W), .DATA_W(DATA_W), .ADDR_W(ADDR_W)) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .flags     (flags),
        .var_floor (var_floor)
    );

    logic result_valid_reg;
    assign adv        = !result_valid_reg || result_ready;
    assign item_ready = adv;

    // input register
    logic         s1_v_reg;
    logic [W-1:0] s1_pm_reg, s1_pv_reg, s1_am_reg, s1_sq_reg, s1_occ_reg, s1_tau_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (adv)
            s1_v_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pm_reg  <= prior_mean;
            s1_pv_reg  <= prior_var;
            s1_am_reg  <= acc_mean;
            s1_sq_reg  <= acc_sq;
            s1_occ_reg <= occupancy;
            s1_tau_reg <= tau;
        end
    end

    // products
    logic [W-1:0]  s1_pm_mag;
    logic          s2_v_reg;
    logic [W2-1:0] s2_pmtau_reg, s2_occpv_reg, s2_taupv_reg;
    logic [W-1:0]  s2_pm_reg, s2_am_reg, s2_sq_reg, s2_occ_reg, s2_tau_reg;

    assign s1_pm_mag = s1_pm_reg[W-1] ? W'(-s1_pm_reg) : s1_pm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (adv)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_pmtau_reg <= W2'(s1_pm_mag) * W2'(s1_tau_reg);
            s2_occpv_reg <= W2'(s1_occ_reg) * W2'(s1_pv_reg);
            s2_taupv_reg <= W2'(s1_tau_reg) * W2'(s1_pv_reg);
            s2_pm_reg    <= s1_pm_reg;
            s2_am_reg    <= s1_am_reg;
            s2_sq_reg    <= s1_sq_reg;
            s2_occ_reg   <= s1_occ_reg;
            s2_tau_reg   <= s1_tau_reg;
        end
    end

    // tau blend numerator, prior weight, ML dividers
    logic signed [MNW:0] ptau_s, am_s, tsum;
    logic [MNW:0]        tsum_neg;
    logic [W2-1:0]       occpv_sh;
    logic [W-1:0]        am_mag;
    side1_t              side1_in, side1_out;
    logic                d1_v, d2_v, d2_neg;
    logic [QW1-1:0]      q1, q2;

    always_comb
    begin
        ptau_s   = $signed((MNW+1)'(s2_pmtau_reg));
        if (s2_pm_reg[W-1])
            ptau_s = -ptau_s;
        am_s     = $signed({{(MNW+1-W){s2_am_reg[W-1]}}, s2_am_reg}) <<< F;
        tsum     = ptau_s + am_s;
        tsum_neg = (MNW+1)'(-tsum);
        occpv_sh = s2_occpv_reg >> F;
        am_mag   = s2_am_reg[W-1] ? W'(-s2_am_reg) : s2_am_reg;

        side1_in.pm       = s2_pm_reg;
        side1_in.tau      = s2_tau_reg;
        side1_in.sq       = s2_sq_reg;
        side1_in.occ_zero = (s2_occ_reg == '0);
        side1_in.dent     = {1'b0, s2_tau_reg} + {1'b0, s2_occ_reg};
        side1_in.taupv    = s2_taupv_reg;
        side1_in.p        = (|occpv_sh[W2-1:W]) ? UMAX : occpv_sh[W-1:0];
        side1_in.tnum_neg = tsum[MNW];
        side1_in.tnum_mag = tsum[MNW] ? tsum_neg[MNW-1:0] : tsum[MNW-1:0];
    end

    gmv_div #(.NW(QW1), .DW(W), .SW($bits(side1_t))) u_div_mlmean (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s2_v_reg),
        .num       ({am_mag, {F{1'b0}}}),
        .den       (s2_occ_reg),
        .side      (side1_in),
        .out_valid (d1_v),
        .quo       (q1),
        .side_out  (side1_out)
    );

    gmv_div #(.NW(QW1), .DW(W), .SW(1)) u_div_mlvar (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s2_v_reg),
        .num       ({s2_sq_reg, {F{1'b0}}}),
        .den       (s2_occ_reg),
        .side      (s2_am_reg[W-1]),
        .out_valid (d2_v),
        .quo       (q2),
        .side_out  (d2_neg)
    );

    // saturate ML mean
    logic           b1_v_reg, b1_mlneg_reg;
    logic [W-1:0]   b1_mlmag_reg;
    logic [QW1-1:0] b1_mv_reg;
    side1_t         b1_side_reg;
    logic [W-1:0]   mlmag;

    always_comb
    begin
        if (d2_neg)
            mlmag = (q1 > QW1'(SMIN)) ? SMIN : q1[W-1:0];
        else
            mlmag = (q1 > QW1'(SMAX)) ? SMAX : q1[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b1_v_reg <= 1'b0;
        else if (adv)
            b1_v_reg <= d1_v && d2_v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_mlmag_reg <= mlmag;
            b1_mlneg_reg <= d2_neg && (mlmag != '0);
            b1_mv_reg    <= q2;
            b1_side_reg  <= side1_out;
        end
    end

    // ML mean squared and ML mean times prior weight
    logic           b2_v_reg, b2_mlneg_reg;
    logic [W2-1:0]  b2_sqm_reg, b2_mlp_reg;
    logic [QW1-1:0] b2_mv_reg;
    side1_t         b2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b2_v_reg <= 1'b0;
        else if (adv)
            b2_v_reg <= b1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b2_sqm_reg   <= W2'(b1_mlmag_reg) * W2'(b1_mlmag_reg);
            b2_mlp_reg   <= W2'(b1_mlmag_reg) * W2'(b1_side_reg.p);
            b2_mlneg_reg <= b1_mlneg_reg;
            b2_mv_reg    <= b1_mv_reg;
            b2_side_reg  <= b1_side_reg;
        end
    end

    // ML variance
    logic           b3_v_reg, b3_mlneg_reg;
    logic [W-1:0]   b3_mlvar_reg;
    logic [W2-1:0]  b3_mlp_reg;
    side1_t         b3_side_reg;
    logic [W2-1:0]  sqm_sh;
    logic [DFW-1:0] mv_diff;
    logic [W-1:0]   mlvar;

    always_comb
    begin
        sqm_sh  = b2_sqm_reg >> F;
        mv_diff = DFW'(b2_mv_reg) - DFW'(sqm_sh);
        if (flags.two_pass)
            mlvar = (|b2_mv_reg[QW1-1:W]) ? UMAX : b2_mv_reg[W-1:0];
        else if (mv_diff[DFW-1])
            mlvar = var_floor;
        else
            mlvar = (|mv_diff[DFW-2:W]) ? UMAX : mv_diff[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b3_v_reg <= 1'b0;
        else if (adv)
            b3_v_reg <= b2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b3_mlvar_reg <= mlvar;
            b3_mlp_reg   <= b2_mlp_reg;
            b3_mlneg_reg <= b2_mlneg_reg;
            b3_side_reg  <= b2_side_reg;
        end
    end

    // prior mean times ML variance
    logic          b4_v_reg, b4_mlneg_reg;
    logic [W-1:0]  b4_mlvar_reg;
    logic [W2-1:0] b4_mlp_reg, b4_pmvar_reg;
    side1_t        b4_side_reg;
    logic [W-1:0]  b3_pm_mag;

    assign b3_pm_mag = b3_side_reg.pm[W-1] ? W'(-b3_side_reg.pm) : b3_side_reg.pm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b4_v_reg <= 1'b0;
        else if (adv)
            b4_v_reg <= b3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b4_pmvar_reg <= W2'(b3_pm_mag) * W2'(b3_mlvar_reg);
            b4_mlvar_reg <= b3_mlvar_reg;
            b4_mlp_reg   <= b3_mlp_reg;
            b4_mlneg_reg <= b3_mlneg_reg;
            b4_side_reg  <= b3_side_reg;
        end
    end

    // mean numerator and denominator select, mean divider
    logic signed [MNW:0] mlp_s, pmv_s, bsum;
    logic [MNW:0]        bsum_neg;
    logic [W:0]          bden;
    logic [MNW-1:0]      mnum;
    logic [W:0]          mden;
    side3_t              side3_in, side3_out;
    logic                d3_v;
    logic [MNW-1:0]      q3;

    always_comb
    begin
        mlp_s = $signed((MNW+1)'(b4_mlp_reg));
        if (b4_mlneg_reg)
            mlp_s = -mlp_s;
        pmv_s = $signed((MNW+1)'(b4_pmvar_reg));
        if (b4_side_reg.pm[W-1])
            pmv_s = -pmv_s;
        bsum     = mlp_s + pmv_s;
        bsum_neg = (MNW+1)'(-bsum);
        bden     = {1'b0, b4_side_reg.p} + {1'b0, b4_mlvar_reg};

        if (flags.mean_mode)
        begin
            mnum              = bsum[MNW] ? bsum_neg[MNW-1:0] : bsum[MNW-1:0];
            mden              = bden;
            side3_in.mnum_neg = bsum[MNW];
        end
        else
        begin
            mnum              = b4_side_reg.tnum_mag;
            mden              = b4_side_reg.dent;
            side3_in.mnum_neg = b4_side_reg.tnum_neg;
        end

        side3_in.pm        = b4_side_reg.pm;
        side3_in.tau       = b4_side_reg.tau;
        side3_in.sq        = b4_side_reg.sq;
        side3_in.occ_zero  = b4_side_reg.occ_zero;
        side3_in.dent      = b4_side_reg.dent;
        side3_in.taupv     = b4_side_reg.taupv;
        side3_in.mden_zero = (mden == '0);
    end

    gmv_div #(.NW(MNW), .DW(W+1), .SW($bits(side3_t))) u_div_mean (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (b4_v_reg),
        .num       (mnum),
        .den       (mden),
        .side      (side3_in),
        .out_valid (d3_v),
        .quo       (q3),
        .side_out  (side3_out)
    );

    // adapted mean
    logic         v0_v_reg, v0_fault_reg;
    logic [W-1:0] v0_mean_reg;
    side3_t       v0_side_reg;
    logic [W-1:0] mean_sel;

    always_comb
    begin
        if (side3_out.occ_zero)
            mean_sel = side3_out.pm;
        else if (side3_out.mden_zero)
            mean_sel = side3_out.mnum_neg ? SMIN : SMAX;
        else if (side3_out.mnum_neg)
            mean_sel = (q3 > MNW'(SMIN)) ? SMIN : W'(-q3[W-1:0]);
        else
            mean_sel = (q3 > MNW'(SMAX)) ? SMAX : q3[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_v_reg <= 1'b0;
        else if (adv)
            v0_v_reg <= d3_v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v0_mean_reg  <= mean_sel;
            v0_fault_reg <= !side3_out.occ_zero && side3_out.mden_zero;
            v0_side_reg  <= side3_out;
        end
    end

    // mean shift magnitude
    logic         v1_v_reg, v1_fault_reg;
    logic [W-1:0] v1_dm_reg, v1_mean_reg;
    side3_t       v1_side_reg;
    logic [W:0]   dmean;

    assign dmean = {v0_side_reg.pm[W-1], v0_side_reg.pm} - {v0_mean_reg[W-1], v0_mean_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_v_reg <= 1'b0;
        else if (adv)
            v1_v_reg <= v0_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v1_dm_reg    <= dmean[W] ? W'(-dmean) : dmean[W-1:0];
            v1_mean_reg  <= v0_mean_reg;
            v1_fault_reg <= v0_fault_reg;
            v1_side_reg  <= v0_side_reg;
        end
    end

    // mean shift squared
    logic          v2_v_reg, v2_fault_reg;
    logic [W2-1:0] v2_dm2_reg;
    logic [W-1:0]  v2_mean_reg;
    side3_t        v2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_v_reg <= 1'b0;
        else if (adv)
            v2_v_reg <= v1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v2_dm2_reg   <= W2'(v1_dm_reg) * W2'(v1_dm_reg);
            v2_mean_reg  <= v1_mean_reg;
            v2_fault_reg <= v1_fault_reg;
            v2_side_reg  <= v1_side_reg;
        end
    end

    // tau times saturated mean shift square
    logic          v3_v_reg, v3_fault_reg;
    logic [W2-1:0] v3_tsqd_reg;
    logic [W-1:0]  v3_mean_reg;
    side3_t        v3_side_reg;
    logic [W2-1:0] dm2_sh;
    logic [W-1:0]  sqd;

    always_comb
    begin
        dm2_sh = v2_dm2_reg >> F;
        sqd    = (|dm2_sh[W2-1:W]) ? UMAX : dm2_sh[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_v_reg <= 1'b0;
        else if (adv)
            v3_v_reg <= v2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v3_tsqd_reg  <= W2'(v2_side_reg.tau) * W2'(sqd);
            v3_mean_reg  <= v2_mean_reg;
            v3_fault_reg <= v2_fault_reg;
            v3_side_reg  <= v2_side_reg;
        end
    end

    // variance numerator and divider
    logic [VNW-1:0] vnum;
    side4_t         side4_in, side4_out;
    logic           d4_v;
    logic [VNW-1:0] q4;

    always_comb
    begin
        vnum = VNW'(v3_side_reg.taupv) + VNW'({v3_side_reg.sq, {F{1'b0}}})
             + VNW'(v3_tsqd_reg);
        side4_in.mean      = v3_mean_reg;
        side4_in.fault_m   = v3_fault_reg;
        side4_in.dent_zero = (v3_side_reg.dent == '0);
    end

    gmv_div #(.NW(VNW), .DW(W+1), .SW($bits(side4_t))) u_div_var (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v3_v_reg),
        .num       (vnum),
        .den       (v3_side_reg.dent),
        .side      (side4_in),
        .out_valid (d4_v),
        .quo       (q4),
        .side_out  (side4_out)
    );

    // output register
    logic [W-1:0] adapted_mean_reg, adapted_var_reg;
    logic         var_valid_reg, div_fault_reg;
    logic         vvalid;
    logic [W-1:0] var_raw, var_fl;

    always_comb
    begin
        vvalid = flags.var_update && !flags.two_pass;
        if (side4_out.dent_zero)
            var_raw = UMAX;
        else
            var_raw = (|q4[VNW-1:W]) ? UMAX : q4[W-1:0];
        var_fl = (var_raw < var_floor) ? var_floor : var_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (adv)
            result_valid_reg <= d4_v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            adapted_mean_reg <= side4_out.mean;
            adapted_var_reg  <= vvalid ? var_fl : '0;
            var_valid_reg    <= vvalid;
            div_fault_reg    <= side4_out.fault_m || (vvalid && side4_out.dent_zero);
        end
    end

    assign result_valid = result_valid_reg;
    assign adapted_mean = adapted_mean_reg;
    assign adapted_var  = adapted_var_reg;
    assign var_valid    = var_valid_reg;
    assign div_fault    = div_fault_reg;

endmodule

// ===== hw/rtl/gmv_checker.sv =====
// Port-level checks for the Gaussian MAP update block, bound to the top level.
`include "assert_macros.svh"

module gmv_checker
#(
    parameter int WORD_WIDTH = 32
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_ready,
    input logic                  result_valid,
    input logic                  result_ready,
    input logic [WORD_WIDTH-1:0] adapted_var,
    input logic                  var_valid
);

    `GMV_ASSERT_RST(a_reset_empty, !rst_n |=> !result_valid, "result word during reset")
    `GMV_ASSERT(a_result_holds, result_valid && !result_ready |=> result_valid,
                "result word dropped while stalled")
    `GMV_ASSERT(a_var_zero, result_valid && !var_valid |-> adapted_var == '0,
                "variance not zero when not valid")
    `GMV_ASSERT(a_accept_on_stall, result_valid && !result_ready |-> !item_ready,
                "item taken while result stalled")

endmodule

bind gaussian_map_mean_var_update gmv_checker #(
    .WORD_WIDTH (WORD_WIDTH)
) u_gmv_checker (.*);
